[rtl/bsg_pkg.sv]
`default_nettype none
package bsg_pkg;

  // fixed field widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned QRY_W    = 17;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned GRAD_W   = 9;

  // working coordinate width: covers (511 << 16) plus sign for fraction widths up to 16
  localparam int unsigned COORD_XW = 26;

  // input word function codes
  typedef enum logic {
    FN_WRITE = 1'b0,
    FN_QUERY = 1'b1
  } func_e;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_DEFAULT = 2'd2
  } cfg_idx_e;

  // effective image size and fill value
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [PIX_W-1:0] dflt;
  } dims_t;

  // one decoded word between front and back
  // xs: query, clamped x-1, clamped x+1, clamped x
  // ys: query, clamped y, clamped y-1, clamped y+1
  typedef struct packed {
    logic                           is_query;
    logic                           wr_ok;
    logic [PIX_W-1:0]               col;
    logic [PIX_W-1:0]               row;
    logic [PIX_W-1:0]               val;
    logic [3:0][COORD_XW-1:0]       xs;
    logic [3:0][COORD_XW-1:0]       ys;
  } qent_t;

endpackage
`default_nettype wire

[rtl/bsg_front.sv]
`default_nettype none
module bsg_front import bsg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                    func_i,
  input  logic [PIX_W-1:0]        pixel_col_i,
  input  logic [PIX_W-1:0]        pixel_row_i,
  input  logic [PIX_W-1:0]        pixel_value_i,
  input  logic signed [QRY_W-1:0] query_x_i,
  input  logic signed [QRY_W-1:0] query_y_i,
  input  dims_t                   dims_i,
  output qent_t                   entry_o
);

  localparam logic signed [COORD_XW-1:0] ONE = COORD_XW'(1) <<< FRAC_BITS;

  function automatic logic signed [COORD_XW-1:0] clamp_coord(
    input logic signed [COORD_XW-1:0] v,
    input logic signed [COORD_XW-1:0] hi
  );
    logic signed [COORD_XW-1:0] r;
    r = v;
    if (r < 0) r = '0;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic signed [COORD_XW-1:0] qx, qy, hi_x, hi_y;

  // upper clamp bounds: (dim - 1) << frac
  assign qx   = COORD_XW'(query_x_i);
  assign qy   = COORD_XW'(query_y_i);
  assign hi_x = ($signed(COORD_XW'(dims_i.width)) <<< FRAC_BITS) - ONE;
  assign hi_y = ($signed(COORD_XW'(dims_i.height)) <<< FRAC_BITS) - ONE;

  // classify and precompute the five sample points
  always_comb begin
    entry_o          = '0;
    entry_o.is_query = (func_i == FN_QUERY);
    entry_o.wr_ok    = (int'(pixel_col_i) < MAX_WIDTH) && (int'(pixel_row_i) < MAX_HEIGHT);
    entry_o.col      = pixel_col_i;
    entry_o.row      = pixel_row_i;
    entry_o.val      = pixel_value_i;
    entry_o.xs[0]    = qx;
    entry_o.xs[1]    = clamp_coord(qx - ONE, hi_x);
    entry_o.xs[2]    = clamp_coord(qx + ONE, hi_x);
    entry_o.xs[3]    = clamp_coord(qx, hi_x);
    entry_o.ys[0]    = qy;
    entry_o.ys[1]    = clamp_coord(qy, hi_y);
    entry_o.ys[2]    = clamp_coord(qy - ONE, hi_y);
    entry_o.ys[3]    = clamp_coord(qy + ONE, hi_y);
  end

endmodule
`default_nettype wire

[rtl/bsg_queue.sv]
`default_nettype none
module bsg_queue import bsg_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t entry_i,
  output logic  ready_o,
  output logic  head_valid_o,
  output qent_t head_o,
  input  logic  pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign ready_o      = (cnt_q != CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/bsg_back.sv]
`default_nettype none
module bsg_back import bsg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  qent_t                      head_i,
  output logic                       pop_o,
  input  dims_t                      dims_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic signed [GRAD_W-1:0]   grad_x_twice_o,
  output logic signed [GRAD_W-1:0]   grad_y_twice_o
);

  localparam int HW  = (MAX_WIDTH + 1) / 2;
  localparam int HH  = (MAX_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int IW  = COORD_XW - FRAC_BITS;
  localparam int FW  = FRAC_BITS + 1;
  localparam int AW  = 2 * FRAC_BITS + 14;

  localparam logic signed [COORD_XW-1:0] ONE    = COORD_XW'(1) <<< FRAC_BITS;
  localparam logic signed [AW-1:0]       HALF   = AW'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [AW-1:0]       SAT_HI = AW'(511);
  localparam logic signed [AW-1:0]       SAT_LO = -AW'(256);

  // the five sample points of a query
  typedef enum logic [4:0] {
    STEP_CENTER = 5'b00001,
    STEP_LEFT   = 5'b00010,
    STEP_RIGHT  = 5'b00100,
    STEP_UP     = 5'b01000,
    STEP_DOWN   = 5'b10000
  } step_e;

  logic adv, stall, issue, wr_en, d_fin;
  step_e step_q, step_d;

  // ---------------- stage A: point select, split, bank addressing
  logic signed [COORD_XW-1:0] px, py;
  logic                       x_out, y_out, x_small, y_small, in_rng;
  logic [IW-1:0]              ix, iy;
  logic signed [FW-1:0]       dx, dy;
  logic [1:0]                 wbank;
  logic [BAW-1:0]             waddr;

  always_comb begin
    case (step_q)
      STEP_CENTER: begin px = $signed(head_i.xs[0]); py = $signed(head_i.ys[0]); end
      STEP_LEFT:   begin px = $signed(head_i.xs[1]); py = $signed(head_i.ys[1]); end
      STEP_RIGHT:  begin px = $signed(head_i.xs[2]); py = $signed(head_i.ys[1]); end
      STEP_UP:     begin px = $signed(head_i.xs[3]); py = $signed(head_i.ys[2]); end
      STEP_DOWN:   begin px = $signed(head_i.xs[3]); py = $signed(head_i.ys[3]); end
      default:     begin px = $signed(head_i.xs[0]); py = $signed(head_i.ys[0]); end
    endcase
  end

  // truncate toward zero; a point in (-1, 0) keeps index 0 and a negative fraction
  always_comb begin
    x_out   = (px <= -ONE);
    y_out   = (py <= -ONE);
    x_small = (px < 0) && !x_out;
    y_small = (py < 0) && !y_out;
    ix      = x_small ? '0 : px[COORD_XW-1:FRAC_BITS];
    iy      = y_small ? '0 : py[COORD_XW-1:FRAC_BITS];
    dx      = x_small ? px[FRAC_BITS:0] : {1'b0, px[FRAC_BITS-1:0]};
    dy      = y_small ? py[FRAC_BITS:0] : {1'b0, py[FRAC_BITS-1:0]};
    in_rng  = !x_out && !y_out &&
              ((IW+1)'(ix) + 1'b1 < (IW+1)'(dims_i.width)) &&
              ((IW+1)'(iy) + 1'b1 < (IW+1)'(dims_i.height));
  end

  // write address: banks interleaved by row and column parity
  assign wbank = {head_i.row[0], head_i.col[0]};
  assign waddr = BAW'(int'(head_i.row >> 1) * HW + int'(head_i.col >> 1));

  assign issue = head_valid_i && head_i.is_query && adv;
  assign wr_en = head_valid_i && !head_i.is_query && head_i.wr_ok && adv;
  assign pop_o = head_valid_i && adv && (!head_i.is_query || (step_q == STEP_DOWN));

  // step sequencer over the five points of a query
  always_comb begin
    case (step_q)
      STEP_CENTER: step_d = STEP_LEFT;
      STEP_LEFT:   step_d = STEP_RIGHT;
      STEP_RIGHT:  step_d = STEP_UP;
      STEP_UP:     step_d = STEP_DOWN;
      STEP_DOWN:   step_d = STEP_CENTER;
      default:     step_d = STEP_CENTER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_CENTER;
    end else if (issue) begin
      step_q <= step_d;
    end
  end

  // four banked image memories, one 2x2 neighborhood per cycle unless the pipe stalls
  logic [PIX_W-1:0] rd_data [4];

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [PIX_W-1:0] mem [BD];
    logic [PIX_W-1:0] rd_q;
    logic [IW:0]      r, c;
    logic [BAW-1:0]   raddr;

    assign r       = (IW+1)'(iy) + (IW+1)'(gb / 2 != int'(iy[0]));
    assign c       = (IW+1)'(ix) + (IW+1)'(gb % 2 != int'(ix[0]));
    assign raddr   = in_rng ? BAW'(int'(r >> 1) * HW + int'(c >> 1)) : '0;
    assign rd_data[gb] = rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en && (wbank == 2'(gb))) mem[waddr] <= head_i.val;
      if (issue) rd_q <= mem[raddr];
    end
  end

  // ---------------- stage B: neighborhood differences and first products
  logic                 b_vld_q, b_in_q, b_px_q, b_py_q;
  step_e                b_step_q;
  logic signed [FW-1:0] b_dx_q, b_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (adv) b_vld_q <= issue;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_in_q   <= in_rng;
      b_px_q   <= ix[0];
      b_py_q   <= iy[0];
      b_step_q <= step_q;
      b_dx_q   <= dx;
      b_dy_q   <= dy;
    end
  end

  logic [PIX_W-1:0]           p00, p01, p10, p11;
  logic signed [9:0]          a3;
  logic signed [8:0]          a1, a2;
  logic signed [FW+8:0]       m1, m2;
  logic signed [FW+9:0]       tm;

  always_comb begin
    p00 = rd_data[{b_py_q, b_px_q}];
    p01 = rd_data[{b_py_q, ~b_px_q}];
    p10 = rd_data[{~b_py_q, b_px_q}];
    p11 = rd_data[{~b_py_q, ~b_px_q}];
    a1  = $signed({1'b0, p01}) - $signed({1'b0, p00});
    a2  = $signed({1'b0, p10}) - $signed({1'b0, p00});
    a3  = $signed({2'b0, p11}) - $signed({2'b0, p01}) - $signed({2'b0, p10})
        + $signed({2'b0, p00});
    m1  = a1 * b_dx_q;
    m2  = a2 * b_dy_q;
    tm  = a3 * b_dx_q;
  end

  // ---------------- stage C: cross term and fixed-point sum
  logic                 c_vld_q, c_in_q;
  step_e                c_step_q;
  logic [PIX_W-1:0]     c_a0_q;
  logic signed [FW+8:0] c_m1_q, c_m2_q;
  logic signed [FW+9:0] c_t_q;
  logic signed [FW-1:0] c_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (adv) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_in_q   <= b_in_q;
      c_step_q <= b_step_q;
      c_a0_q   <= p00;
      c_m1_q   <= m1;
      c_m2_q   <= m2;
      c_t_q    <= tm;
      c_dy_q   <= b_dy_q;
    end
  end

  logic signed [2*FW+9:0] m3;
  logic signed [AW-1:0]   acc;

  always_comb begin
    m3  = c_t_q * c_dy_q;
    acc = (AW'($signed({1'b0, c_a0_q})) <<< (2 * FRAC_BITS))
        + ((AW'(c_m1_q) + AW'(c_m2_q)) <<< FRAC_BITS)
        + AW'(m3);
  end

  // ---------------- stage D: round half away from zero, saturate, collect
  logic                 d_vld_q, d_in_q;
  step_e                d_step_q;
  logic signed [AW-1:0] d_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (adv) d_vld_q <= c_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_in_q   <= c_in_q;
      d_step_q <= c_step_q;
      d_acc_q  <= acc;
    end
  end

  logic signed [AW-1:0]       mag, rnd, rv;
  logic signed [SAMPLE_W-1:0] val;

  always_comb begin
    mag = (d_acc_q < 0) ? -d_acc_q : d_acc_q;
    rnd = (mag + HALF) >>> (2 * FRAC_BITS);
    rv  = (d_acc_q < 0) ? -rnd : rnd;
    if (!d_in_q)          val = $signed({2'b00, dims_i.dflt});
    else if (rv > SAT_HI) val = SAT_HI[SAMPLE_W-1:0];
    else if (rv < SAT_LO) val = SAT_LO[SAMPLE_W-1:0];
    else                  val = rv[SAMPLE_W-1:0];
  end

  // the whole pipe holds while a finished word waits on a full output
  assign d_fin = d_vld_q && (d_step_q == STEP_DOWN);
  assign stall = d_fin && out_valid_o && !out_ready_i;
  assign adv   = !stall;

  logic signed [SAMPLE_W-1:0] smp_q, gl_q, gr_q, gu_q;
  logic signed [SAMPLE_W:0]   gx_full, gy_full;

  always_ff @(posedge clk_i) begin
    if (adv && d_vld_q) begin
      case (d_step_q)
        STEP_CENTER: smp_q <= val;
        STEP_LEFT:   gl_q  <= val;
        STEP_RIGHT:  gr_q  <= val;
        STEP_UP:     gu_q  <= val;
        default:     ;
      endcase
    end
  end

  assign gx_full = (SAMPLE_W+1)'(gr_q) - (SAMPLE_W+1)'(gl_q);
  assign gy_full = (SAMPLE_W+1)'(val) - (SAMPLE_W+1)'(gu_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (d_fin && adv) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (d_fin && adv) begin
      sample_o       <= smp_q;
      grad_x_twice_o <= gx_full[GRAD_W-1:0];
      grad_y_twice_o <= gy_full[GRAD_W-1:0];
    end
  end

endmodule
`default_nettype wire

[rtl/bilinear_sampler_with_gradient_unit.sv]
// Bilinear sampler with central-difference gradient.
// Input channel (in_valid_i/in_ready_o): func_i = 0 writes pixel_value_i at
// (pixel_row_i, pixel_col_i); func_i = 1 queries point (query_x_i, query_y_i),
// signed fixed point with FRAC_BITS fraction bits.
// Output channel (out_valid_o/out_ready_i): one word per query carrying the
// rounded sample and twice the x and y gradients. Writes give no word.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 width, 1 height,
// 2 default value; always ready, write only while the block is idle.
// A query visits its five sample points in turn, a write is one memory write;
// the limit is the four banked image memories, which deliver one 2x2
// neighborhood per cycle unless the pipe stalls. A query's word passes stage A
// and the B, C, D and output registers. A 2-word queue between decode and the
// sampling pipe absorbs stalls. When the receiver stalls, the pipe freezes
// with the finished word held and input is taken until the queue is full.
// Reset: config returns to 256 x 256 with default 0; the image is undefined
// until written and no clearing pass is run.
`default_nettype none
module bilinear_sampler_with_gradient_unit import bsg_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [PIX_W-1:0]           pixel_col_i,
  input  logic [PIX_W-1:0]           pixel_row_i,
  input  logic [PIX_W-1:0]           pixel_value_i,
  input  logic signed [QRY_W-1:0]    query_x_i,
  input  logic signed [QRY_W-1:0]    query_y_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic signed [GRAD_W-1:0]   grad_x_twice_o,
  output logic signed [GRAD_W-1:0]   grad_y_twice_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [DIM_W-1:0]           cfg_data_i
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [PIX_W-1:0] dflt_q;
  dims_t            dims;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      dflt_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:   width_q  <= cfg_data_i;
        CFG_HEIGHT:  height_q <= cfg_data_i;
        CFG_DEFAULT: dflt_q   <= cfg_data_i[PIX_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective dimensions, capped at the store size
  always_comb begin
    dims.width  = (int'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
    dims.height = (int'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;
    dims.dflt   = dflt_q;
  end

  qent_t front_entry, head;
  logic  head_valid, pop;

  bsg_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .func_i       (func_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .pixel_value_i(pixel_value_i),
    .query_x_i    (query_x_i),
    .query_y_i    (query_y_i),
    .dims_i       (dims),
    .entry_o      (front_entry)
  );

  bsg_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .entry_i     (front_entry),
    .ready_o     (in_ready_o),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  bsg_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .dims_i        (dims),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .grad_x_twice_o(grad_x_twice_o),
    .grad_y_twice_o(grad_y_twice_o)
  );

endmodule
`default_nettype wire

[rtl/bsg_checker.sv]
`default_nettype none
module bsg_checker import bsg_pkg::*; (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic signed [SAMPLE_W-1:0] sample_o,
  input wire logic signed [GRAD_W-1:0]   grad_x_twice_o,
  input wire logic signed [GRAD_W-1:0]   grad_y_twice_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) &&
    $stable(grad_x_twice_o) && $stable(grad_y_twice_o))
    else $error("output word changed while stalled");

  // a word leaves only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output word dropped");

  // clamped gradient samples lie in pixel range, so the difference never hits the minimum code
  a_gx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> grad_x_twice_o != 9'h100)
    else $error("x gradient out of range");

  a_gy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> grad_y_twice_o != 9'h100)
    else $error("y gradient out of range");

endmodule

bind bilinear_sampler_with_gradient_unit bsg_checker u_bsg_checker (.*);
`default_nettype wire
